// ===== rtl/core/crc16pr_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-16 packet receiver package
// Shared types, register indexes, reset values and the CRC update function.
// ----------------------------------------------------------------------------
package crc16pr_pkg;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 256;

   localparam logic [7:0]  HEADER_FIRST_RESET   = 8'hF0;
   localparam logic [7:0]  HEADER_SECOND_RESET  = 8'hAA;
   localparam logic        LOW_BYTE_FIRST_RESET = 1'b1;
   localparam logic [15:0] IDLE_LIMIT_RESET     = 16'd50;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_FIRST   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SECOND  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_BYTE_FIRST = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT     = 2'd3;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [2:0] {
      PH_SYNC1  = 3'd0,
      PH_SYNC2  = 3'd1,
      PH_CMD    = 3'd2,
      PH_LEN1   = 3'd3,
      PH_LEN2   = 3'd4,
      PH_DATA   = 3'd5,
      PH_CRC1   = 3'd6,
      PH_CRC2   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EV_CMD      = 3'd0,
      EV_DATA     = 3'd1,
      EV_GOOD     = 3'd2,
      EV_BADCRC   = 3'd3,
      EV_OVERFLOW = 3'd4,
      EV_IDLE     = 3'd5
   } event_type;

   // XMODEM form: MSB first, no reflection, one byte per call.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/crc16_packet_receiver_core.sv =====
// ----------------------------------------------------------------------------
// CRC-16 packet receiver core
// Deframes sync/command/length/payload/CRC packets from a stream of byte and
// tick beats, streaming the command and payload and reporting the packet end.
// ----------------------------------------------------------------------------
// A result appears on rsp_ in the cycle after its request beat is taken.
// Throughput: one request beat per cycle; the state update and CRC step for a
// byte are a single pass of combinational logic into the state and rsp_
// registers, and a held result only stalls req_ while rsp_ready is low.
// Reset clears the receive state and restores the register defaults.
module crc16_packet_receiver_core #(
   parameter int unsigned MAX_PAYLOAD = crc16pr_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [7:0]                          req_rx_byte,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_event_res,
   output logic [7:0]                          rsp_out_byte,
   output logic [7:0]                          rsp_byte_index,
   output logic [15:0]                         rsp_data_length,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [crc16pr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crc16pr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned EXT_W = 17;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

   // Configuration registers
   logic [7:0]  header_first_ff;
   logic [7:0]  header_second_ff;
   logic        low_byte_first_ff;
   logic [15:0] idle_limit_ff;

   // Receive state
   crc16pr_pkg::phase_type phase_ff, phase_in;
   logic [15:0]      running_crc_ff, running_crc_in;
   logic [15:0]      received_crc_ff, received_crc_in;
   logic [15:0]      declared_length_ff, declared_length_in;
   logic [CNT_W-1:0] payload_count_ff, payload_count_in;
   logic [15:0]      idle_ticks_ff, idle_ticks_in;
   logic             byte_seen_ff, byte_seen_in;

   // Result register
   logic                   rsp_valid_ff;
   crc16pr_pkg::event_type rsp_event_ff, rsp_event_in;
   logic [7:0]             rsp_out_byte_ff, rsp_out_byte_in;
   logic [7:0]             rsp_byte_index_ff, rsp_byte_index_in;
   logic [15:0]            rsp_data_length_ff, rsp_data_length_in;
   logic                   emit_in;

   logic             req_fire;
   logic [15:0]      crc_step;
   logic [15:0]      second_half;
   logic [CNT_W-1:0] count_inc;
   logic [EXT_W-1:0] count_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_event_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_byte_index  = rsp_byte_index_ff;
   assign rsp_data_length = rsp_data_length_ff;

   // The first sync byte always restarts the CRC from zero, and the running
   // value is zero whenever the receiver is hunting, so one step serves all.
   assign crc_step  = crc16pr_pkg::crc16_byte(running_crc_ff, req_rx_byte);
   assign count_inc = payload_count_ff + CNT_W'(1);
   assign count_ext = {{(EXT_W - CNT_W){1'b0}}, payload_count_ff};

   always_comb begin
      if (low_byte_first_ff) begin
         second_half = {req_rx_byte, declared_length_ff[7:0]};
      end else begin
         second_half = {declared_length_ff[15:8], req_rx_byte};
      end
   end

   always_comb begin
      phase_in           = phase_ff;
      running_crc_in     = running_crc_ff;
      received_crc_in    = received_crc_ff;
      declared_length_in = declared_length_ff;
      payload_count_in   = payload_count_ff;
      idle_ticks_in      = idle_ticks_ff;
      byte_seen_in       = byte_seen_ff;
      emit_in            = 1'b0;
      rsp_event_in       = crc16pr_pkg::EV_CMD;
      rsp_out_byte_in    = 8'h00;
      rsp_byte_index_in  = 8'h00;
      rsp_data_length_in = declared_length_ff;

      if (req_fire) begin
         if (req_kind == crc16pr_pkg::KIND_TICK) begin
            if (byte_seen_ff) begin
               if (idle_ticks_ff >= idle_limit_ff) begin
                  phase_in           = crc16pr_pkg::PH_SYNC1;
                  running_crc_in     = 16'h0000;
                  received_crc_in    = 16'h0000;
                  declared_length_in = 16'h0000;
                  payload_count_in   = '0;
                  idle_ticks_in      = 16'h0000;
                  byte_seen_in       = 1'b0;
                  // Losing a receiver that was only hunting is not reported.
                  emit_in      = (phase_ff != crc16pr_pkg::PH_SYNC1);
                  rsp_event_in = crc16pr_pkg::EV_IDLE;
               end else begin
                  idle_ticks_in = idle_ticks_ff + 16'd1;
               end
            end
         end else begin
            idle_ticks_in = 16'h0000;
            byte_seen_in  = 1'b1;
            case (phase_ff)
               crc16pr_pkg::PH_SYNC1: begin
                  if (req_rx_byte == header_first_ff) begin
                     running_crc_in = crc_step;
                     phase_in       = crc16pr_pkg::PH_SYNC2;
                  end
               end
               crc16pr_pkg::PH_SYNC2: begin
                  if (req_rx_byte == header_second_ff) begin
                     running_crc_in = crc_step;
                     phase_in       = crc16pr_pkg::PH_CMD;
                  end
               end
               crc16pr_pkg::PH_CMD: begin
                  running_crc_in     = crc_step;
                  phase_in           = crc16pr_pkg::PH_LEN1;
                  emit_in            = 1'b1;
                  rsp_event_in       = crc16pr_pkg::EV_CMD;
                  rsp_out_byte_in    = req_rx_byte;
                  rsp_data_length_in = 16'h0000;
               end
               crc16pr_pkg::PH_LEN1: begin
                  declared_length_in = low_byte_first_ff ? {8'h00, req_rx_byte}
                                                         : {req_rx_byte, 8'h00};
                  running_crc_in     = crc_step;
                  phase_in           = crc16pr_pkg::PH_LEN2;
               end
               crc16pr_pkg::PH_LEN2: begin
                  declared_length_in = second_half;
                  running_crc_in     = crc_step;
                  phase_in = (second_half == 16'h0000) ? crc16pr_pkg::PH_CRC1
                                                       : crc16pr_pkg::PH_DATA;
               end
               crc16pr_pkg::PH_DATA: begin
                  emit_in = 1'b1;
                  if (payload_count_ff == CNT_MAX) begin
                     phase_in           = crc16pr_pkg::PH_SYNC1;
                     running_crc_in     = 16'h0000;
                     received_crc_in    = 16'h0000;
                     declared_length_in = 16'h0000;
                     payload_count_in   = '0;
                     byte_seen_in       = 1'b0;
                     rsp_event_in       = crc16pr_pkg::EV_OVERFLOW;
                  end else begin
                     running_crc_in    = crc_step;
                     payload_count_in  = count_inc;
                     rsp_event_in      = crc16pr_pkg::EV_DATA;
                     rsp_out_byte_in   = req_rx_byte;
                     rsp_byte_index_in = count_ext[7:0];
                     if ({{(EXT_W - CNT_W){1'b0}}, count_inc} ==
                         {1'b0, declared_length_ff}) begin
                        phase_in = crc16pr_pkg::PH_CRC1;
                     end
                  end
               end
               crc16pr_pkg::PH_CRC1: begin
                  received_crc_in = low_byte_first_ff ? {8'h00, req_rx_byte}
                                                      : {req_rx_byte, 8'h00};
                  phase_in        = crc16pr_pkg::PH_CRC2;
               end
               default: begin
                  emit_in = 1'b1;
                  if (low_byte_first_ff) begin
                     rsp_event_in = ({req_rx_byte, received_crc_ff[7:0]} == running_crc_ff)
                                    ? crc16pr_pkg::EV_GOOD : crc16pr_pkg::EV_BADCRC;
                  end else begin
                     rsp_event_in = ({received_crc_ff[15:8], req_rx_byte} == running_crc_ff)
                                    ? crc16pr_pkg::EV_GOOD : crc16pr_pkg::EV_BADCRC;
                  end
                  phase_in           = crc16pr_pkg::PH_SYNC1;
                  running_crc_in     = 16'h0000;
                  received_crc_in    = 16'h0000;
                  declared_length_in = 16'h0000;
                  payload_count_in   = '0;
                  byte_seen_in       = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= crc16pr_pkg::PH_SYNC1;
         running_crc_ff     <= 16'h0000;
         received_crc_ff    <= 16'h0000;
         declared_length_ff <= 16'h0000;
         payload_count_ff   <= '0;
         idle_ticks_ff      <= 16'h0000;
         byte_seen_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         running_crc_ff     <= running_crc_in;
         received_crc_ff    <= received_crc_in;
         declared_length_ff <= declared_length_in;
         payload_count_ff   <= payload_count_in;
         idle_ticks_ff      <= idle_ticks_in;
         byte_seen_ff       <= byte_seen_in;
         if (req_fire) begin
            rsp_valid_ff <= emit_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit_in) begin
         rsp_event_ff       <= rsp_event_in;
         rsp_out_byte_ff    <= rsp_out_byte_in;
         rsp_byte_index_ff  <= rsp_byte_index_in;
         rsp_data_length_ff <= rsp_data_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff   <= crc16pr_pkg::HEADER_FIRST_RESET;
         header_second_ff  <= crc16pr_pkg::HEADER_SECOND_RESET;
         low_byte_first_ff <= crc16pr_pkg::LOW_BYTE_FIRST_RESET;
         idle_limit_ff     <= crc16pr_pkg::IDLE_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crc16pr_pkg::CSR_HEADER_FIRST:   header_first_ff   <= csr_wdata[7:0];
            crc16pr_pkg::CSR_HEADER_SECOND:  header_second_ff  <= csr_wdata[7:0];
            crc16pr_pkg::CSR_LOW_BYTE_FIRST: low_byte_first_ff <= csr_wdata[0];
            crc16pr_pkg::CSR_IDLE_LIMIT:     idle_limit_ff     <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== tb/crc16_packet_receiver_core_tb.sv =====
// ----------------------------------------------------------------------------
// CRC-16 packet receiver core testbench
// Drives byte and tick beats into the receiver and checks every event. A
// local model tracks the framing state, the running CRC and the idle timer.
// Stimulus covers short directed frames, idle timeouts, both byte orders, a
// full and an overflowing payload, a long output stall, a large idle limit
// and random traffic under random idling on both channels.
// ----------------------------------------------------------------------------
module crc16_packet_receiver_core_tb;
   import crc16pr_pkg::*;

   localparam int unsigned PAYLOAD_CAP  = MAX_PAYLOAD_DEFAULT;
   localparam int          RANDOM_BEATS = 60;
   localparam int          HOLD_CYCLES  = 80;
   localparam int          CYCLE_LIMIT  = 1000000;

   typedef struct {
      event_type   ev;
      logic [7:0]  data;
      logic [7:0]  pos;
      logic [15:0] len;
   } rx_event_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_kind;
   logic [7:0]             req_rx_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [2:0]             rsp_event_res;
   logic [7:0]             rsp_out_byte;
   logic [7:0]             rsp_byte_index;
   logic [15:0]            rsp_data_length;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Register copies held by the model.
   logic [7:0]  cfg_hdr1       = HEADER_FIRST_RESET;
   logic [7:0]  cfg_hdr2       = HEADER_SECOND_RESET;
   logic        cfg_lsb_first  = LOW_BYTE_FIRST_RESET;
   logic [15:0] cfg_idle_limit = IDLE_LIMIT_RESET;

   // Receive state held by the model.
   phase_type   rx_phase     = PH_SYNC1;
   logic [15:0] rx_crc       = '0;
   logic [15:0] got_crc      = '0;
   logic [15:0] decl_len     = '0;
   int          stored_count = 0;
   logic [15:0] idle_count   = '0;
   bit          seen_byte    = 1'b0;

   rx_event_t   expected_events[$];
   int          fail_count   = 0;
   int          work_beats   = 0;
   int          cycle_count  = 0;
   bit          gaps_on      = 1'b1;
   bit          stalls_on    = 1'b1;
   bit          hold_request = 1'b0;

   crc16_packet_receiver_core #(
      .MAX_PAYLOAD(PAYLOAD_CAP)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_data_length(rsp_data_length),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Model of the receiver
   // ------------------------------------------------------------------------

   // Shift-register form of the XMODEM CRC, one data bit per step.
   function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] d);
      logic [15:0] crc;
      logic        fb;
      int          i;
      crc = crc_in;
      for (i = 7; i >= 0; i--) begin
         fb  = crc[15] ^ d[i];
         crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return crc;
   endfunction

   function automatic logic [15:0] place_half(input logic [15:0] acc, input logic [7:0] c,
                                              input bit first);
      if ((cfg_lsb_first == 1'b1) == first) return {acc[15:8], c};
      return {c, acc[7:0]};
   endfunction

   function automatic void clear_receiver();
      rx_phase     = PH_SYNC1;
      rx_crc       = '0;
      got_crc      = '0;
      decl_len     = '0;
      stored_count = 0;
      idle_count   = '0;
      seen_byte    = 1'b0;
   endfunction

   // Advances the model by one beat; returns 1 when the beat yields an event.
   function automatic bit predict_beat(input logic kind, input logic [7:0] d,
                                       output rx_event_t res);
      phase_type   was;
      logic [15:0] len_held;
      res = '{EV_CMD, 8'h00, 8'h00, 16'h0000};
      if (kind == KIND_TICK) begin
         if (!seen_byte) return 1'b0;
         if (idle_count >= cfg_idle_limit) begin
            was      = rx_phase;
            len_held = decl_len;
            clear_receiver();
            if (was == PH_SYNC1) return 1'b0;
            res = '{EV_IDLE, 8'h00, 8'h00, len_held};
            return 1'b1;
         end
         idle_count++;
         return 1'b0;
      end
      idle_count = '0;
      seen_byte  = 1'b1;
      case (rx_phase)
         PH_SYNC1: begin
            if (d == cfg_hdr1) begin
               rx_crc   = crc_step(16'h0000, d);
               rx_phase = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (d == cfg_hdr2) begin
               rx_crc   = crc_step(rx_crc, d);
               rx_phase = PH_CMD;
            end
         end
         PH_CMD: begin
            rx_crc   = crc_step(rx_crc, d);
            rx_phase = PH_LEN1;
            res      = '{EV_CMD, d, 8'h00, 16'h0000};
            return 1'b1;
         end
         PH_LEN1: begin
            decl_len = place_half(16'h0000, d, 1'b1);
            rx_crc   = crc_step(rx_crc, d);
            rx_phase = PH_LEN2;
         end
         PH_LEN2: begin
            decl_len = place_half(decl_len, d, 1'b0);
            rx_crc   = crc_step(rx_crc, d);
            rx_phase = (decl_len == 16'h0000) ? PH_CRC1 : PH_DATA;
         end
         PH_DATA: begin
            // A full store drops the byte and abandons the packet.
            if (stored_count == PAYLOAD_CAP) begin
               len_held = decl_len;
               clear_receiver();
               res = '{EV_OVERFLOW, 8'h00, 8'h00, len_held};
               return 1'b1;
            end
            rx_crc = crc_step(rx_crc, d);
            res    = '{EV_DATA, d, stored_count[7:0], decl_len};
            stored_count++;
            if (stored_count == decl_len) rx_phase = PH_CRC1;
            return 1'b1;
         end
         PH_CRC1: begin
            got_crc  = place_half(16'h0000, d, 1'b1);
            rx_phase = PH_CRC2;
         end
         default: begin
            got_crc  = place_half(got_crc, d, 1'b0);
            len_held = decl_len;
            res      = '{(got_crc == rx_crc) ? EV_GOOD : EV_BADCRC, 8'h00, 8'h00, len_held};
            clear_receiver();
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking and output stalls
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      rx_event_t want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $error("event_res: no event expected, got %0d", rsp_event_res);
            fail_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_res", 16'(want.ev), 16'(rsp_event_res));
            check_field("out_byte", 16'(want.data), 16'(rsp_out_byte));
            check_field("byte_index", 16'(want.pos), 16'(rsp_byte_index));
            check_field("data_length", want.len, rsp_data_length);
         end
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(15, 40);
   endfunction

   initial begin : rsp_stalls
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            // Long hold-off so that the block backs up into its input.
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_ready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_length()) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Beat and register traffic
   // ------------------------------------------------------------------------

   task automatic offer_beat(input logic kind, input logic [7:0] d);
      rx_event_t res;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!(kind == KIND_TICK && !seen_byte)) work_beats++;
      if (predict_beat(kind, d, res)) expected_events.push_back(res);
   endtask

   task automatic send_byte(input logic [7:0] d);
      offer_beat(KIND_BYTE, d);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) offer_beat(KIND_TICK, 8'($urandom));
   endtask

   // Waits until every expected event has come out and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] h1, input logic [7:0] h2, input logic lsb,
                            input logic [15:0] limit);
      logic [CSR_INDEX_W-1:0] regs[4] = '{CSR_HEADER_FIRST, CSR_HEADER_SECOND,
                                          CSR_LOW_BYTE_FIRST, CSR_IDLE_LIMIT};
      logic [15:0]            values[4];
      int                     i;
      values = '{16'(h1), 16'(h2), 16'(lsb), limit};
      settle();
      for (i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (regs[i])
            CSR_HEADER_FIRST:   cfg_hdr1       = values[i][7:0];
            CSR_HEADER_SECOND:  cfg_hdr2       = values[i][7:0];
            CSR_LOW_BYTE_FIRST: cfg_lsb_first  = values[i][0];
            default:            cfg_idle_limit = values[i];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Sends one frame under the current settings. fill < 0 gives random payload,
   // max_ticks bounds the ticks slipped in between bytes, and cut_at >= 0 keeps
   // only that many bytes of the frame.
   task automatic send_packet(input logic [7:0] cmd, input logic [15:0] len, input int fill,
                              input logic [15:0] crc_flip, input int max_ticks,
                              input int cut_at);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      int          i;
      frame = {cfg_hdr1, cfg_hdr2, cmd};
      if (cfg_lsb_first) frame = {frame, len[7:0], len[15:8]};
      else frame = {frame, len[15:8], len[7:0]};
      for (i = 0; i < len && (cut_at < 0 || frame.size() < cut_at); i++)
         frame.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      crc = 16'h0000;
      foreach (frame[k]) crc = crc_step(crc, frame[k]);
      crc ^= crc_flip;
      if (cfg_lsb_first) frame = {frame, crc[7:0], crc[15:8]};
      else frame = {frame, crc[15:8], crc[7:0]};
      if (cut_at >= 0) while (frame.size() > cut_at) void'(frame.pop_back());
      foreach (frame[k]) begin
         if (k > 0 && max_ticks > 0 && $urandom_range(0, 3) == 0)
            send_ticks($urandom_range(0, max_ticks));
         send_byte(frame[k]);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_directed_frames();
      send_ticks(2);                 // no byte seen yet, so the timer is stopped
      send_byte(8'h00);              // not a sync byte
      send_byte(cfg_hdr1);
      send_byte(8'hFF);              // wrong second sync byte, still waiting
      send_packet(8'hFF, 16'h0001, 8'h00, 16'h0000, 0, -1);
      send_packet(8'h00, 16'h0000, -1, 16'h8000, 0, -1);
      send_packet(8'h5A, 16'h0002, 8'hFF, 16'h0000, 0, -1);
   endtask

   task automatic test_idle_timeout();
      configure(HEADER_FIRST_RESET, HEADER_SECOND_RESET, LOW_BYTE_FIRST_RESET, 16'd1);
      send_byte(8'h11);
      send_ticks(2);                 // silent clear while hunting
      send_byte(cfg_hdr1);
      send_ticks(2);
      send_packet(8'h42, 16'h1234, -1, 16'h0000, 0, 5);
      send_ticks(2);
      send_packet(8'h43, 16'h0003, -1, 16'h0000, 1, -1);
   endtask

   task automatic test_byte_order_and_headers();
      configure(8'h00, 8'hFF, 1'b0, 16'hFFFF);
      send_packet(8'h81, 16'h0003, -1, 16'h0000, 2, -1);
      send_packet(8'h7E, 16'h0005, -1, 16'h0001, 0, -1);
      configure(8'hFF, 8'h00, 1'b1, 16'd1);
      send_packet(8'h18, 16'h0004, -1, 16'h0000, 1, -1);
      send_packet(8'hE7, 16'h0000, -1, 16'h0100, 0, -1);
   endtask

   task automatic test_payload_limits();
      configure(HEADER_FIRST_RESET, HEADER_SECOND_RESET, 1'b0, IDLE_LIMIT_RESET);
      send_packet(8'hA5, 16'(PAYLOAD_CAP), -1, 16'h0000, 0, -1);
      // One byte beyond the store: sync, command and length take five bytes.
      send_packet(8'h5A, 16'hFFFF, -1, 16'h0000, 0, 5 + PAYLOAD_CAP + 1);
   endtask

   task automatic test_backpressure();
      hold_request = 1'b1;
      gaps_on      = 1'b0;
      send_packet(8'hC3, 16'd30, -1, 16'h0000, 0, -1);
      gaps_on      = 1'b1;
      settle();
   endtask

   task automatic test_long_idle();
      configure(HEADER_FIRST_RESET, HEADER_SECOND_RESET, 1'b1, 16'hFFFF);
      gaps_on = 1'b0;
      send_packet(8'h3C, 16'h0004, -1, 16'h0000, 0, 3);
      // Well inside the limit, so the partial frame survives the quiet spell.
      send_ticks(12);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      gaps_on = 1'b1;
   endtask

   task automatic send_random_frame();
      int          pick;
      logic [15:0] len;
      int          n;
      pick      = $urandom_range(0, 99);
      gaps_on   = ($urandom_range(0, 4) != 0);
      stalls_on = ($urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                        : 16'($urandom_range(0, 6));
      if (pick < 70) begin
         if ($urandom_range(0, 4) == 0) send_byte(8'($urandom));
         send_packet(8'($urandom), len, -1,
                     ($urandom_range(0, 6) == 0) ? 16'(16'h0001 << $urandom_range(0, 15))
                                                 : 16'h0000,
                     int'(cfg_idle_limit), -1);
      end else if (pick < 85) begin
         send_packet(8'($urandom), len, -1, 16'h0000, 0, $urandom_range(1, len + 6));
      end else begin
         if ($urandom_range(0, 1)) send_byte(cfg_hdr1);
         n = $urandom_range(1, 4);
         repeat (n) begin
            if ($urandom_range(0, 2) != 0) send_byte(8'($urandom));
            else send_ticks(1);
         end
      end
      // Let the idle timer drop whatever is left of a broken frame.
      if (rx_phase != PH_SYNC1) send_ticks(int'(cfg_idle_limit) + 1);
   endtask

   task automatic test_random_traffic();
      int goal;
      int p;
      for (p = 0; p < 4; p++) begin
         configure(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                   16'($urandom_range(1, 12)));
         goal = work_beats + RANDOM_BEATS / 4;
         while (work_beats < goal) send_random_frame();
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   initial begin : main
      int n;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_kind    <= KIND_BYTE;
      req_rx_byte <= 8'h00;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_HEADER_FIRST;
      csr_wdata   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_idle_timeout();
      test_byte_order_and_headers();
      test_payload_limits();
      test_backpressure();
      test_long_idle();
      test_random_traffic();

      req_valid <= 1'b0;
      for (n = 0; n < 5000 && expected_events.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (expected_events.size() != 0) begin
         $error("%0d expected events never came out", expected_events.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
